// File: hdl/trie_word_set_engine_unit_macros.svh
// Assertion macros shared by the trie word set engine RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef TRIE_WORD_SET_ENGINE_UNIT_MACROS_SVH
`define TRIE_WORD_SET_ENGINE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every rising edge outside reset.
`define TWSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("twse assertion failed");
// Expression that must never be true outside reset.
`define TWSE_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("twse forbidden condition seen");
`else
`define TWSE_ASSERT(lbl, prop)
`define TWSE_ASSERT_NEVER(lbl, expr)
`endif

`endif

// File: hdl/twse_pkg.sv
// Shared types, codes and the symbol decoder of the trie word set engine.
// No dependencies; used by twse_ctrl, twse_dpath and the top level.
package twse_pkg;

  localparam int SYMBOLS = 53;
  localparam int CODE_W  = 6;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_DEL = 2'd1;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FOUND    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_ERASED   = 3'd3;
  localparam logic [2:0] ST_DELFAIL  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_BADCHAR  = 3'd6;

  localparam logic [1:0] FAIL_NONE    = 2'd0;
  localparam logic [1:0] FAIL_ABSENT  = 2'd1;
  localparam logic [1:0] FAIL_FULL    = 2'd2;
  localparam logic [1:0] FAIL_BADCHAR = 2'd3;

  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] code;
  } sym_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_wr;
    logic accept;
    logic look;
    logic zero_wr;
    logic result;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_go;
    logic word_end_in;
    logic word_end;
    logic link_hit;
    logic can_alloc;
  } ctl_sts_t;

  // Upper case maps to 0..25, lower case to 26..51, space to 52.
  function automatic sym_t sym_decode(input logic [7:0] ch);
    sym_t s;
    s.ok   = 1'b1;
    s.code = '0;
    if (ch == 8'h20) begin
      s.code = 6'd52;
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      s.code = 6'(ch - 8'h61) + 6'd26;
    end else if (ch >= 8'h41 && ch <= 8'h5a) begin
      s.code = 6'(ch - 8'h41);
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

// File: hdl/twse_ctrl.sv
// Sequencer of the trie word set engine: steps each item through lookup,
// node creation, count read and result. Depends on twse_pkg.
module twse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  twse_pkg::ctl_sts_t  sts,
  output logic                busy,
  output twse_pkg::ctl_cmd_t  cmd
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_ZERO   = 3'd3;
  localparam logic [2:0] S_CREAD  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (sts.walk_go) begin
            state_nxt = S_LOOK;
          end else if (sts.word_end_in) begin
            state_nxt = S_CREAD;
          end
        end
      end
      S_LOOK: begin
        cmd.look = 1'b1;
        if (!sts.link_hit && sts.can_alloc) begin
          state_nxt = S_ZERO;
        end else if (sts.word_end) begin
          state_nxt = S_CREAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ZERO: begin
        cmd.zero_wr = 1'b1;
        state_nxt   = sts.word_end ? S_CREAD : S_IDLE;
      end
      S_CREAD: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        cmd.result = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: hdl/twse_dpath.sv
// Datapath of the trie word set engine: child link and count memories,
// walk registers and result registers. Depends on twse_pkg and the macros.
`include "trie_word_set_engine_unit_macros.svh"

module twse_dpath #(
  parameter int NODE_CAPACITY = 4096,
  parameter int COUNT_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  twse_pkg::ctl_cmd_t  cmd,
  output twse_pkg::ctl_sts_t  sts,
  input  logic [1:0]          in_opcode,
  input  logic [7:0]          in_symbol,
  input  logic                in_has_symbol,
  input  logic                in_last_symbol,
  output logic                out_strobe,
  output logic [2:0]          out_status,
  output logic [15:0]         out_word_count
);

  localparam int IDX_W = (NODE_CAPACITY > 2) ? $clog2(NODE_CAPACITY) : 1;
  localparam int NU_W  = $clog2(NODE_CAPACITY + 1);

  typedef logic [twse_pkg::SYMBOLS-1:0][IDX_W-1:0] row_t;

  // One row per node holds all of its child links.
  row_t                  link_mem [NODE_CAPACITY];
  logic [COUNT_BITS-1:0] cnt_mem  [NODE_CAPACITY];

  row_t                        row_rd_r;
  logic [COUNT_BITS-1:0]       cnt_rd_r;
  logic [IDX_W-1:0]            cur_node_r, cur_node_nxt;
  logic [NU_W-1:0]             nodes_used_r, nodes_used_nxt;
  logic [1:0]                  fail_r, fail_nxt;
  logic [1:0]                  op_r;
  logic [twse_pkg::CODE_W-1:0] code_r;
  logic                        last_r;
  logic                        out_strobe_r;
  logic [2:0]                  out_status_r;
  logic [15:0]                 out_word_count_r;

  twse_pkg::sym_t        sym;
  logic [IDX_W-1:0]      link;
  logic [IDX_W-1:0]      new_idx;
  logic                  link_hit;
  logic                  full;
  logic                  can_alloc;
  logic                  alloc;
  logic                  row_we;
  row_t                  row_wd;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [COUNT_BITS-1:0] res_count;
  logic [2:0]            res_status;
  logic                  res_upd;
  logic                  cnt_zero;
  logic [31:0]           cnt_wide;

  assign sym       = twse_pkg::sym_decode(in_symbol);
  assign link      = row_rd_r[code_r];
  assign link_hit  = (link != '0);
  assign full      = (nodes_used_r == NU_W'(NODE_CAPACITY));
  assign new_idx   = nodes_used_r[IDX_W-1:0];
  assign can_alloc = (op_r == twse_pkg::OP_ADD) && !full;
  assign alloc     = cmd.look && !link_hit && can_alloc;

  assign sts.walk_go     = in_has_symbol && sym.ok && (fail_r == twse_pkg::FAIL_NONE);
  assign sts.word_end_in = in_last_symbol;
  assign sts.word_end    = last_r;
  assign sts.link_hit    = link_hit;
  assign sts.can_alloc   = can_alloc;

  // A fresh node's row and count are zeroed when it is allocated, so rows of
  // unallocated nodes are never read and the memories need no clearing.
  assign row_we = cmd.init_wr || cmd.zero_wr || alloc;

  always_comb begin
    row_wd         = row_rd_r;
    row_wd[code_r] = new_idx;
    if (!cmd.look) begin
      row_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      link_mem[cur_node_r] <= row_wd;
    end
    row_rd_r <= link_mem[cur_node_r];
  end

  assign cnt_zero = (cnt_rd_r == '0);

  always_comb begin
    res_count  = '0;
    res_upd    = 1'b0;
    res_status = twse_pkg::ST_BADCHAR;
    if (fail_r != twse_pkg::FAIL_BADCHAR) begin
      case (op_r)
        twse_pkg::OP_ADD: begin
          if (fail_r == twse_pkg::FAIL_FULL) begin
            res_status = twse_pkg::ST_FULL;
          end else begin
            res_status = twse_pkg::ST_ADDED;
            res_count  = (cnt_rd_r == '1) ? cnt_rd_r : cnt_rd_r + 1'b1;
            res_upd    = 1'b1;
          end
        end
        twse_pkg::OP_DEL: begin
          if (fail_r != twse_pkg::FAIL_NONE || cnt_zero) begin
            res_status = twse_pkg::ST_DELFAIL;
          end else begin
            res_status = twse_pkg::ST_ERASED;
            res_count  = cnt_rd_r - 1'b1;
            res_upd    = 1'b1;
          end
        end
        default: begin
          if (fail_r != twse_pkg::FAIL_NONE || cnt_zero) begin
            res_status = twse_pkg::ST_NOTFOUND;
          end else begin
            res_status = twse_pkg::ST_FOUND;
            res_count  = cnt_rd_r;
          end
        end
      endcase
    end
  end

  assign cnt_we   = cmd.init_wr || cmd.zero_wr || (cmd.result && res_upd);
  assign cnt_wd   = cmd.result ? res_count : '0;
  assign cnt_wide = 32'(res_count);

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cur_node_r] <= cnt_wd;
    end
    cnt_rd_r <= cnt_mem[cur_node_r];
  end

  always_comb begin
    cur_node_nxt   = cur_node_r;
    nodes_used_nxt = nodes_used_r;
    fail_nxt       = fail_r;
    if (cmd.accept && in_has_symbol && !sym.ok) begin
      fail_nxt = twse_pkg::FAIL_BADCHAR;
    end
    if (cmd.look) begin
      if (link_hit) begin
        cur_node_nxt = link;
      end else if (alloc) begin
        cur_node_nxt   = new_idx;
        nodes_used_nxt = nodes_used_r + 1'b1;
      end else if (op_r != twse_pkg::OP_ADD) begin
        fail_nxt = twse_pkg::FAIL_ABSENT;
      end else begin
        fail_nxt = twse_pkg::FAIL_FULL;
      end
    end
    if (cmd.result) begin
      cur_node_nxt = '0;
      fail_nxt     = twse_pkg::FAIL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_node_r   <= '0;
      nodes_used_r <= NU_W'(1);
      fail_r       <= twse_pkg::FAIL_NONE;
      out_strobe_r <= 1'b0;
    end else begin
      cur_node_r   <= cur_node_nxt;
      nodes_used_r <= nodes_used_nxt;
      fail_r       <= fail_nxt;
      out_strobe_r <= cmd.result;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_opcode;
      code_r <= sym.code;
      last_r <= in_last_symbol;
    end
    if (cmd.result) begin
      out_status_r     <= res_status;
      out_word_count_r <= cnt_wide[15:0];
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_word_count = out_word_count_r;

  `TWSE_ASSERT(a_nodes_bound, nodes_used_r <= NU_W'(NODE_CAPACITY) && nodes_used_r != '0)
  `TWSE_ASSERT(a_cur_allocated, NU_W'(cur_node_r) < nodes_used_r)
  `TWSE_ASSERT(a_result_rewinds, cmd.result |=> out_strobe_r && cur_node_r == '0)
  `TWSE_ASSERT_NEVER(a_alloc_when_full, alloc && full)

endmodule

// File: hdl/trie_word_set_engine_unit.sv
// Trie word multiset engine: add, delete and check words one byte per transfer.
// A walking character passes through the lookup state, and through the zeroing state
// as well when it creates a node (registered row read); a word end then passes through
// the count read and result states, and the result strobe is registered after those.
// Reset: synchronous, active low; one busy cycle after reset zeroes the root node.
// The result is shown for exactly one cycle and the receiver cannot stall it.
module trie_word_set_engine_unit #(
  parameter int NODE_CAPACITY = 4096,
  parameter int COUNT_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_symbol,
  input  logic        in_has_symbol,
  input  logic        in_last_symbol,
  output logic        busy,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [15:0] out_word_count
);

  // The controller sequences each transfer through lookup, optional node
  // creation, count read and result; the datapath owns both memories.
  // An input transfer happens on a rising edge with start high and busy low.
  // Nodes are allocated in order, and each new node has its row of child
  // links and its count zeroed as it is created, so only allocated rows are
  // ever read and no clearing pass is needed beyond the root after reset.
  // Failures within a word (absent prefix, full table, bad character) are
  // latched and reported when the last symbol of the word arrives.

  twse_pkg::ctl_cmd_t cmd;
  twse_pkg::ctl_sts_t sts;

  twse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  twse_dpath #(
    .NODE_CAPACITY (NODE_CAPACITY),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_symbol      (in_symbol),
    .in_has_symbol  (in_has_symbol),
    .in_last_symbol (in_last_symbol),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_word_count (out_word_count)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the trie word multiset engine (trie_word_set_engine_unit).
// Needs twse_pkg for the opcode, status and walk failure codes; reads no files.
`timescale 1ns / 1ps

module testbench;

  // The package names add and delete only. Opcode 3 is decoded like a check.
  localparam logic [1:0] OP_CHECK     = 2'd2;
  localparam logic [1:0] OP_ALT_CHECK = 2'd3;

  localparam int          TRIE_NODES = 4096;
  localparam int          HIT_BITS   = 16;
  localparam logic [15:0] HIT_MAX    = 16'hFFFF;
  localparam int          BAD_BRANCH = -1;
  localparam int          SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] count;
  } word_result_t;

  // One row of the directed table. Rows with typed set carry their own expected
  // result; all other rows take theirs from the trie predictor.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic        has;
    logic        last;
    logic        typed;
    logic [2:0]  status;
    logic [15:0] count;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic [1:0]  in_opcode;
  logic [7:0]  in_symbol;
  logic        in_has_symbol;
  logic        in_last_symbol;
  logic        busy;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [15:0] out_word_count;

  trie_word_set_engine_unit #(
    .NODE_CAPACITY(TRIE_NODES),
    .COUNT_BITS   (HIT_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_opcode     (in_opcode),
    .in_symbol     (in_symbol),
    .in_has_symbol (in_has_symbol),
    .in_last_symbol(in_last_symbol),
    .busy          (busy),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_word_count(out_word_count)
  );

  // Predictor state: a private copy of the trie. Node 0 is the root, and a zero
  // link means "no child" because the root is never anybody's child.
  bit   [11:0] branch_tbl [TRIE_NODES*twse_pkg::SYMBOLS];
  bit   [15:0] node_hits  [TRIE_NODES];
  logic [11:0] cursor     = '0;
  int          alloc_count = 1;
  logic [1:0]  walk_err   = twse_pkg::FAIL_NONE;

  // Expected results in transfer order, oldest first.
  word_result_t pending_results[$];
  int           mismatch_count = 0;
  int           word_items     = 0;
  bit           gaps_on        = 1'b1;

  // A narrow alphabet made of the range edges and space, so that random words
  // collide often and checks and deletes find their targets.
  logic [7:0] few_chars [5] = '{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h20};

  // Directed table: empty-trie lookups, add/check/delete round trips, the space
  // symbol, the empty word, an idle item, opcode 3, mixed opcodes inside one word
  // and the priority of a bad character over the other walk failures.
  stim_row_t directed_rows [26] = '{
    '{OP_CHECK,         8'h41, 1'b1, 1'b1, 1'b1, twse_pkg::ST_NOTFOUND, 16'd0},
    '{twse_pkg::OP_DEL, 8'h7A, 1'b1, 1'b1, 1'b1, twse_pkg::ST_DELFAIL,  16'd0},
    '{OP_CHECK,         8'h00, 1'b0, 1'b1, 1'b1, twse_pkg::ST_NOTFOUND, 16'd0},
    '{twse_pkg::OP_ADD, 8'h41, 1'b1, 1'b0, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_ADD, 8'h7A, 1'b1, 1'b1, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_ADD, 8'h41, 1'b1, 1'b0, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_ADD, 8'h7A, 1'b1, 1'b1, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{OP_CHECK,         8'h41, 1'b1, 1'b0, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{OP_CHECK,         8'h7A, 1'b1, 1'b1, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_DEL, 8'h41, 1'b1, 1'b0, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_DEL, 8'h7A, 1'b1, 1'b1, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_ADD, 8'h20, 1'b1, 1'b1, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_ADD, 8'hFF, 1'b0, 1'b1, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{OP_CHECK,         8'h55, 1'b0, 1'b0, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{OP_ALT_CHECK,     8'h41, 1'b1, 1'b0, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{OP_ALT_CHECK,     8'h7A, 1'b1, 1'b1, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_ADD, 8'h5A, 1'b1, 1'b0, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{OP_CHECK,         8'h61, 1'b1, 1'b1, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{OP_CHECK,         8'h5A, 1'b1, 1'b0, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_ADD, 8'h61, 1'b1, 1'b1, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_ADD, 8'h41, 1'b1, 1'b0, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_ADD, 8'h00, 1'b1, 1'b0, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_ADD, 8'h7A, 1'b1, 1'b1, 1'b1, twse_pkg::ST_BADCHAR,  16'd0},
    '{twse_pkg::OP_DEL, 8'h71, 1'b1, 1'b0, 1'b0, twse_pkg::ST_ADDED,    16'd0},
    '{twse_pkg::OP_DEL, 8'hFF, 1'b1, 1'b1, 1'b1, twse_pkg::ST_BADCHAR,  16'd0},
    '{twse_pkg::OP_DEL, 8'h2A, 1'b0, 1'b1, 1'b0, twse_pkg::ST_ADDED,    16'd0}
  };

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest legal run (every item creating a node and ending a
  // word, each behind the longest idle gap) stays under 200 us; this allows
  // about ten times that.
  initial begin
    #2ms;
    $display("** trie_word_set_engine_unit: FAILED **");
    $finish;
  end

  // Maps a byte onto its branch: 'A'..'Z' first, then 'a'..'z', then space.
  function automatic int char_to_branch(input logic [7:0] ch);
    if (ch == 8'h20) return twse_pkg::SYMBOLS - 1;
    if (ch >= 8'h61 && ch <= 8'h7A) return 26 + int'(ch - 8'h61);
    if (ch >= 8'h41 && ch <= 8'h5A) return int'(ch - 8'h41);
    return BAD_BRANCH;
  endfunction

  // Advances the predicted trie by one accepted transfer. The walk step moves the
  // cursor one level down (creating the node for an add); a word end settles the
  // count of the node reached and resets the walk for the next word.
  function automatic void trie_apply(input logic [1:0] op, input logic [7:0] ch,
                                     input logic has, input logic last,
                                     output bit produced, output word_result_t res);
    int          branch;
    int          slot;
    logic [11:0] nxt;
    logic [11:0] node;

    branch = char_to_branch(ch);
    if (has) begin
      if (branch == BAD_BRANCH) begin
        // A bad character outranks every other failure code.
        walk_err = twse_pkg::FAIL_BADCHAR;
      end else if (walk_err == twse_pkg::FAIL_NONE) begin
        slot = int'(cursor) * twse_pkg::SYMBOLS + branch;
        nxt  = branch_tbl[slot];
        if (nxt == '0) begin
          if (op != twse_pkg::OP_ADD) begin
            walk_err = twse_pkg::FAIL_ABSENT;
          end else if (alloc_count >= TRIE_NODES) begin
            walk_err = twse_pkg::FAIL_FULL;
          end else begin
            nxt = 12'(alloc_count);
            branch_tbl[slot] = nxt;
            alloc_count++;
          end
        end
        if (walk_err == twse_pkg::FAIL_NONE) cursor = nxt;
      end
    end

    produced   = last;
    res.status = twse_pkg::ST_NOTFOUND;
    res.count  = '0;
    if (!last) return;

    node = cursor;
    if (walk_err == twse_pkg::FAIL_BADCHAR) begin
      res.status = twse_pkg::ST_BADCHAR;
    end else if (op == twse_pkg::OP_ADD) begin
      // An add that stalled on an absent link (mixed opcodes) still counts at
      // the node where the walk stopped.
      if (walk_err == twse_pkg::FAIL_FULL) begin
        res.status = twse_pkg::ST_FULL;
      end else begin
        if (node_hits[node] != HIT_MAX) node_hits[node]++;
        res.status = twse_pkg::ST_ADDED;
        res.count  = node_hits[node];
      end
    end else if (op == twse_pkg::OP_DEL) begin
      if (walk_err != twse_pkg::FAIL_NONE || node_hits[node] == '0) begin
        res.status = twse_pkg::ST_DELFAIL;
      end else begin
        node_hits[node]--;
        res.status = twse_pkg::ST_ERASED;
        res.count  = node_hits[node];
      end
    end else begin
      if (walk_err != twse_pkg::FAIL_NONE || node_hits[node] == '0) begin
        res.status = twse_pkg::ST_NOTFOUND;
      end else begin
        res.status = twse_pkg::ST_FOUND;
        res.count  = node_hits[node];
      end
    end
    cursor   = '0;
    walk_err = twse_pkg::FAIL_NONE;
  endfunction

  // Offers one item, optionally after a random idle gap, and holds it until the
  // block takes it. The caller is always just past a rising edge, and the item
  // is driven there with nonblocking assignments. Busy is sampled right after
  // the edge, so it still holds the value that decided the transfer.
  task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                           input logic has, input logic last,
                           input bit typed = 1'b0,
                           input logic [2:0] t_status = twse_pkg::ST_ADDED,
                           input logic [15:0] t_count = '0);
    bit           produced;
    word_result_t res;
    int           gap;

    if (gaps_on && $urandom_range(99) < 19) begin
      start <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= op;
    in_symbol      <= ch;
    in_has_symbol  <= has;
    in_last_symbol <= last;
    do @(posedge clk); while (busy);

    trie_apply(op, ch, has, last, produced, res);
    if (produced) begin
      if (typed) begin
        res.status = t_status;
        res.count  = t_count;
      end
      pending_results = {pending_results, res};
    end
    if (has || last) word_items++;
  endtask

  // Stops offering items and waits until every expected result has come back.
  // At least one edge passes, so the next item never lands in this time step.
  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [7:0] pick_char(input bit wide);
    int r;
    if (!wide) return few_chars[$urandom_range(4)];
    r = $urandom_range(twse_pkg::SYMBOLS - 1);
    if (r < 26) return 8'h41 + 8'(r);
    if (r < 52) return 8'h61 + 8'(r - 26);
    return 8'h20;
  endfunction

  // One random word: mostly well formed with a single opcode, sometimes with
  // an idle item in front, a raw byte inside, a stray opcode on one character,
  // or a separate empty end item instead of marking the last character.
  task automatic send_random_word();
    int         r;
    int         len;
    bit         wide;
    bit         split_end;
    logic [1:0] op;
    logic [1:0] item_op;
    logic [7:0] ch;

    r  = $urandom_range(99);
    op = (r < 40) ? twse_pkg::OP_ADD : (r < 60) ? twse_pkg::OP_DEL :
         (r < 92) ? OP_CHECK : OP_ALT_CHECK;
    wide      = ($urandom_range(99) < 15);
    len       = wide ? $urandom_range(4, 10) : $urandom_range(0, 3);
    split_end = (len > 0) && ($urandom_range(99) < 10);

    if ($urandom_range(99) < 8)
      send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, 1'b0);
    for (int i = 0; i < len; i++) begin
      ch = pick_char(wide);
      if ($urandom_range(99) < 3) ch = 8'($urandom_range(255));
      item_op = ($urandom_range(99) < 5) ? 2'($urandom_range(3)) : op;
      send_item(item_op, ch, 1'b1, (i == len - 1) && !split_end);
    end
    if (len == 0 || split_end)
      send_item(op, 8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Result checker. A strobe lasts exactly one cycle and cannot be held off, so
  // each one is compared against the oldest expectation at the edge that ends it.
  always @(posedge clk) begin
    word_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                 $time, out_status, out_word_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_status);
          mismatch_count++;
        end
        if (out_word_count !== want.count) begin
          $display("%0t: word count mismatch, expected %0d, actual %0d",
                   $time, want.count, out_word_count);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int base_items;

    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_opcode      <= twse_pkg::OP_ADD;
    in_symbol      <= '0;
    in_has_symbol  <= 1'b0;
    in_last_symbol <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. The block spends one busy cycle clearing the root after
    // reset; the handshake absorbs it.
    foreach (directed_rows[k])
      send_item(directed_rows[k].op, directed_rows[k].ch, directed_rows[k].has,
                directed_rows[k].last, directed_rows[k].typed,
                directed_rows[k].status, directed_rows[k].count);

    // Random words over a mostly narrow alphabet. A stretch in the middle runs
    // without any idle gaps so that items arrive back to back.
    base_items = word_items;
    while (word_items < base_items + 900) begin
      gaps_on = !(word_items >= base_items + 500 && word_items < base_items + 700);
      send_random_word();
    end
    gaps_on = 1'b1;

    // Sender holds off until the block has nothing left in flight.
    wait_results_drained();

    while (word_items < base_items + 1380)
      send_random_word();

    // Wait out every expected result, then keep watching for stray results.
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** trie_word_set_engine_unit: PASSED **");
    end else begin
      $display("** trie_word_set_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
